// ----- design/prwf_pkg.sv -----
// ----------------------------------------------------------------------------
// prwf_pkg
// shared types and constants for the packet receive window filter
// ----------------------------------------------------------------------------
package prwf_pkg;

    localparam int KEY_W           = 16;
    localparam int SEQ_W           = 8;
    localparam int KIND_W          = 8;
    localparam int WIN_W           = 32;
    localparam int SHIFT_W         = $clog2(WIN_W);
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // register index, taken from paddr word bit
    typedef enum logic {
        REG_EXPECTED_KEY  = 1'b0,
        REG_ACK_TYPE_CODE = 1'b1
    } reg_idx_t;

    // header after classification by the front end
    typedef struct packed {
        logic             key_ok;
        logic             is_ack;
        logic             reliable_flag;
        logic [SEQ_W-1:0] sequence_number;
        logic [SEQ_W-1:0] first_payload_byte;
    } item_t;

    // one result item
    typedef struct packed {
        logic             discard;
        logic             duplicate;
        logic             send_ack;
        logic [SEQ_W-1:0] ack_out_sequence;
        logic             acked_valid;
        logic [SEQ_W-1:0] acked_sequence;
        logic [SEQ_W-1:0] newest_seen;
        logic [WIN_W-1:0] window_bits;
    } result_t;

endpackage

// ----- design/prwf_front.sv -----
// ----------------------------------------------------------------------------
// prwf_front
// input stage: takes a header, checks key and type, registers the class
// ----------------------------------------------------------------------------
module prwf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [prwf_pkg::KEY_W-1:0]    expected_key,
    input  logic [prwf_pkg::KIND_W-1:0]   ack_type_code,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [prwf_pkg::KEY_W-1:0]    s_header_key,
    input  logic                          s_reliable_flag,
    input  logic [prwf_pkg::SEQ_W-1:0]    s_sequence_number,
    input  logic [prwf_pkg::KIND_W-1:0]   s_packet_kind,
    input  logic [prwf_pkg::SEQ_W-1:0]    s_first_payload_byte,
    output logic                          push_valid,
    input  logic                          push_ready,
    output prwf_pkg::item_t               push_item
);
    import prwf_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  s_xfer;

    // stage frees up when empty or when its item moves into the queue
    assign s_ready    = !valid_reg || push_ready;
    assign s_xfer     = s_valid && s_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    // classify the incoming header
    always_comb begin
        item_next                    = item_reg;
        valid_next                   = valid_reg && !push_ready;
        if (s_xfer) begin
            item_next.key_ok             = (s_header_key == expected_key);
            item_next.is_ack             = (s_packet_kind == ack_type_code);
            item_next.reliable_flag      = s_reliable_flag;
            item_next.sequence_number    = s_sequence_number;
            item_next.first_payload_byte = s_first_payload_byte;
            valid_next                   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

// ----- design/prwf_queue.sv -----
// ----------------------------------------------------------------------------
// prwf_queue
// small fifo between the front end and the window logic
// ----------------------------------------------------------------------------
module prwf_queue #(
    parameter int DEPTH = prwf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  prwf_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output prwf_pkg::item_t pop_item
);
    import prwf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/prwf_back.sv -----
// ----------------------------------------------------------------------------
// prwf_back
// window update and duplicate check, registered result output
// ----------------------------------------------------------------------------
module prwf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  prwf_pkg::item_t    pop_item,
    output logic               m_valid,
    input  logic               m_ready,
    output prwf_pkg::result_t  result
);
    import prwf_pkg::*;

    logic [SEQ_W-1:0] newest_reg;
    logic [SEQ_W-1:0] newest_next;
    logic [WIN_W-1:0] bitmap_reg;
    logic [WIN_W-1:0] bitmap_next;
    logic             valid_reg;
    logic             valid_next;
    result_t          result_reg;
    result_t          result_next;

    logic [SEQ_W-1:0] ahead;
    logic [SEQ_W-1:0] behind;
    logic             is_newer;
    logic             big_gap;
    logic             in_window;
    logic [WIN_W-1:0] back_mask;
    logic             dup;
    logic             take;
    logic             win_op;

    assign pop_ready = !valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;
    assign m_valid   = valid_reg;
    assign result    = result_reg;

    // wraparound distance to the newest sequence
    // a distance of exactly half the range is newer only when seq is below newest
    assign ahead     = pop_item.sequence_number - newest_reg;
    assign behind    = newest_reg - pop_item.sequence_number;
    assign is_newer  = (ahead != '0) &&
                       (!ahead[SEQ_W-1] ||
                        ((ahead[SEQ_W-2:0] == '0) &&
                         (pop_item.sequence_number < newest_reg)));
    assign big_gap   = (ahead[SEQ_W-1:SHIFT_W] != '0);
    assign in_window = (behind[SEQ_W-1:SHIFT_W] == '0);
    assign back_mask = {{(WIN_W-1){1'b0}}, 1'b1} << behind[SHIFT_W-1:0];
    assign win_op    = pop_item.key_ok && !pop_item.is_ack;
    assign dup       = win_op && !is_newer && in_window && ((bitmap_reg & back_mask) != '0);

    // next window state and result
    always_comb begin
        newest_next = newest_reg;
        bitmap_next = bitmap_reg;
        valid_next  = valid_reg && !m_ready;
        result_next = result_reg;
        if (take) begin
            if (win_op) begin
                if (is_newer) begin
                    newest_next = pop_item.sequence_number;
                    if (big_gap) begin
                        bitmap_next = {{(WIN_W-1){1'b0}}, 1'b1};
                    end else begin
                        bitmap_next = (bitmap_reg << ahead[SHIFT_W-1:0])
                                      | {{(WIN_W-1){1'b0}}, 1'b1};
                    end
                end else if (in_window) begin
                    bitmap_next = bitmap_reg | back_mask;
                end
            end
            valid_next                   = 1'b1;
            result_next.discard          = !pop_item.key_ok || dup;
            result_next.duplicate        = dup;
            result_next.send_ack         = pop_item.key_ok && pop_item.reliable_flag;
            result_next.ack_out_sequence = (pop_item.key_ok && pop_item.reliable_flag)
                                           ? pop_item.sequence_number : '0;
            result_next.acked_valid      = pop_item.key_ok && pop_item.is_ack;
            result_next.acked_sequence   = (pop_item.key_ok && pop_item.is_ack)
                                           ? pop_item.first_payload_byte : '0;
            result_next.newest_seen      = newest_next;
            result_next.window_bits      = bitmap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg <= '0;
            bitmap_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            newest_reg <= newest_next;
            bitmap_reg <= bitmap_next;
            valid_reg  <= valid_next;
        end
        result_reg <= result_next;
    end

endmodule

// ----- design/packet_receive_window_filter_unit.sv -----
// ----------------------------------------------------------------------------
// packet_receive_window_filter_unit
// receive filter with 32-entry sliding-window duplicate detection
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one parsed header per transfer (valid/ready).
//   m_* channel returns one result per header, in order (valid/ready).
//   APB port sets expected_key (0x0) and ack_type_code (0x4); write only
//   while no header is in flight.
// Timing:
//   a header passes the front register, a queue entry and the result
//   register, in that order, before m_valid rises. One header per cycle
//   is sustained while m_ready stays high; the window update
//   (subtract, shift, or-in) completes in the cycle the back end pops the queue.
// Stalls:
//   when m_ready is low the result register holds, the queue fills
//   (QUEUE_DEPTH entries) and then the front register; s_ready drops once
//   all are full. Each side stalls independently of the other.
// Reset:
//   synchronous active-low aresetn empties all stages, clears the newest
//   sequence and bitmap to 0 and both config registers to 0.
// ----------------------------------------------------------------------------
module packet_receive_window_filter_unit #(
    parameter int QUEUE_DEPTH = prwf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [prwf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [prwf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [prwf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // header input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [prwf_pkg::KEY_W-1:0]         s_header_key,
    input  logic                               s_reliable_flag,
    input  logic [prwf_pkg::SEQ_W-1:0]         s_sequence_number,
    input  logic [prwf_pkg::KIND_W-1:0]        s_packet_kind,
    input  logic [prwf_pkg::SEQ_W-1:0]         s_first_payload_byte,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_discard,
    output logic                               m_duplicate,
    output logic                               m_send_ack,
    output logic [prwf_pkg::SEQ_W-1:0]         m_ack_out_sequence,
    output logic                               m_acked_valid,
    output logic [prwf_pkg::SEQ_W-1:0]         m_acked_sequence,
    output logic [prwf_pkg::SEQ_W-1:0]         m_newest_seen,
    output logic [prwf_pkg::WIN_W-1:0]         m_window_bits
);
    import prwf_pkg::*;

    logic [KEY_W-1:0]  expected_key_reg;
    logic [KEY_W-1:0]  expected_key_next;
    logic [KIND_W-1:0] ack_type_code_reg;
    logic [KIND_W-1:0] ack_type_code_next;
    reg_idx_t          reg_idx;
    logic              cfg_wr;

    logic    push_valid;
    logic    push_ready;
    item_t   push_item;
    logic    pop_valid;
    logic    pop_ready;
    item_t   pop_item;
    result_t result;

    // config register file
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        expected_key_next  = expected_key_reg;
        ack_type_code_next = ack_type_code_reg;
        prdata             = '0;
        unique case (reg_idx)
            REG_EXPECTED_KEY: begin
                prdata = APB_DATA_W'(expected_key_reg);
                if (cfg_wr) begin
                    expected_key_next = pwdata[KEY_W-1:0];
                end
            end
            REG_ACK_TYPE_CODE: begin
                prdata = APB_DATA_W'(ack_type_code_reg);
                if (cfg_wr) begin
                    ack_type_code_next = pwdata[KIND_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_key_reg  <= '0;
            ack_type_code_reg <= '0;
        end else begin
            expected_key_reg  <= expected_key_next;
            ack_type_code_reg <= ack_type_code_next;
        end
    end

    // front end: accept and classify
    prwf_front u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .expected_key         (expected_key_reg),
        .ack_type_code        (ack_type_code_reg),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_header_key         (s_header_key),
        .s_reliable_flag      (s_reliable_flag),
        .s_sequence_number    (s_sequence_number),
        .s_packet_kind        (s_packet_kind),
        .s_first_payload_byte (s_first_payload_byte),
        .push_valid           (push_valid),
        .push_ready           (push_ready),
        .push_item            (push_item)
    );

    // decoupling queue
    prwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // back end: window update and result register
    prwf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result)
    );

    assign m_discard          = result.discard;
    assign m_duplicate        = result.duplicate;
    assign m_send_ack         = result.send_ack;
    assign m_ack_out_sequence = result.ack_out_sequence;
    assign m_acked_valid      = result.acked_valid;
    assign m_acked_sequence   = result.acked_sequence;
    assign m_newest_seen      = result.newest_seen;
    assign m_window_bits      = result.window_bits;

    // a duplicate is always discarded
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_duplicate |-> m_discard)
        else $error("duplicate result not discarded");

    // an acknowledgement never touches the window, so it is never a duplicate
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_acked_valid |-> !m_duplicate)
        else $error("ack packet flagged as duplicate");

    // no ack requested means a zero ack sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_send_ack |-> (m_ack_out_sequence == '0))
        else $error("ack sequence set without send_ack");

    // input backpressure only when the whole pipeline is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (push_valid && !push_ready && pop_valid && m_valid))
        else $error("s_ready low while a stage has room");

endmodule

// ----- test/packet_receive_window_filter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_receive_window_filter_unit_tb
// self-checking bench for the receive window filter
// ----------------------------------------------------------------------------
// Headers are pushed through the s_ channel and every result on the m_
// channel is checked field by field against an in-bench prediction of the
// key filter, ack reporting and 32-entry sliding window. A directed run
// covers key mismatch, acks, wraparound, large gaps and far-behind headers.
// Randomized runs follow under several key / ack-code settings, with random
// backpressure on either side and final runs without any idling.
// ----------------------------------------------------------------------------
module packet_receive_window_filter_unit_tb;

    import prwf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEG_HEADERS  = 255;
    localparam int NUM_SEGMENTS = 6;
    localparam int DRAIN_CYCLES = 8;

    // one parsed header as the bench sees it
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              reliable;
        logic [SEQ_W-1:0]  seq;
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  payload;
    } header_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // header channel
    logic              s_valid              = 1'b0;
    logic              s_ready;
    logic [KEY_W-1:0]  s_header_key         = '0;
    logic              s_reliable_flag      = 1'b0;
    logic [SEQ_W-1:0]  s_sequence_number    = '0;
    logic [KIND_W-1:0] s_packet_kind        = '0;
    logic [SEQ_W-1:0]  s_first_payload_byte = '0;

    // result channel
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_discard;
    logic              m_duplicate;
    logic              m_send_ack;
    logic [SEQ_W-1:0]  m_ack_out_sequence;
    logic              m_acked_valid;
    logic [SEQ_W-1:0]  m_acked_sequence;
    logic [SEQ_W-1:0]  m_newest_seen;
    logic [WIN_W-1:0]  m_window_bits;

    // bench-side copy of registers and window state
    logic [KEY_W-1:0]  cfg_key    = '0;
    logic [KIND_W-1:0] cfg_ack    = '0;
    logic [SEQ_W-1:0]  win_newest = '0;
    logic [WIN_W-1:0]  win_bitmap = '0;

    header_t pending_headers[$];
    result_t expected_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count     = 0;
    int n_checked     = 0;
    int n_key_miss    = 0;
    int n_dup         = 0;
    int n_acked       = 0;
    int n_win_reset   = 0;
    int cycle_count   = 0;

    logic [SEQ_W-1:0] gen_cursor = '0;

    packet_receive_window_filter_unit u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_header_key         (s_header_key),
        .s_reliable_flag      (s_reliable_flag),
        .s_sequence_number    (s_sequence_number),
        .s_packet_kind        (s_packet_kind),
        .s_first_payload_byte (s_first_payload_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_discard            (m_discard),
        .m_duplicate          (m_duplicate),
        .m_send_ack           (m_send_ack),
        .m_ack_out_sequence   (m_ack_out_sequence),
        .m_acked_valid        (m_acked_valid),
        .m_acked_sequence     (m_acked_sequence),
        .m_newest_seen        (m_newest_seen),
        .m_window_bits        (m_window_bits)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // filter one header and advance the window state
    function automatic result_t filter_header(input header_t h);
        result_t r;
        int      gap;
        int      back;
        r = '0;
        if (h.key != cfg_key) begin
            r.discard = 1'b1;
            n_key_miss++;
        end else begin
            if (h.reliable) begin
                r.send_ack         = 1'b1;
                r.ack_out_sequence = h.seq;
            end
            if (h.kind == cfg_ack) begin
                r.acked_valid    = 1'b1;
                r.acked_sequence = h.payload;
                n_acked++;
            end else begin
                // signed distance with 8-bit wraparound
                gap = int'(h.seq) - int'(win_newest);
                if (gap < -127)
                    gap += 256;
                else if (gap > 127)
                    gap -= 256;
                if (gap > 0) begin
                    if (gap > 31) begin
                        win_bitmap = 32'd1;
                        n_win_reset++;
                    end else begin
                        win_bitmap = (win_bitmap << gap) | 32'd1;
                    end
                    win_newest = h.seq;
                end else begin
                    back = -gap;
                    // far-behind headers leave the window alone
                    if (back < 32) begin
                        if (win_bitmap[back]) begin
                            r.duplicate = 1'b1;
                            r.discard   = 1'b1;
                            n_dup++;
                        end
                        win_bitmap[back] = 1'b1;
                    end
                end
            end
        end
        r.newest_seen = win_newest;
        r.window_bits = win_bitmap;
        return r;
    endfunction

    function automatic header_t make_header(input logic [KEY_W-1:0] key, input logic rel,
                                            input logic [SEQ_W-1:0] seq,
                                            input logic [KIND_W-1:0] kind,
                                            input logic [SEQ_W-1:0] payload);
        header_t h;
        h.key      = key;
        h.reliable = rel;
        h.seq      = seq;
        h.kind     = kind;
        h.payload  = payload;
        return h;
    endfunction

    // random header: mostly an orderly stream around a moving cursor
    function automatic header_t random_header();
        header_t h;
        int      pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            gen_cursor = gen_cursor + SEQ_W'($urandom_range(1, 4));
            h.seq = gen_cursor;
        end else if (pick < 80) begin
            h.seq = gen_cursor - SEQ_W'($urandom_range(0, 33));
        end else if (pick < 88) begin
            h.seq = gen_cursor;
        end else if (pick < 94) begin
            gen_cursor = gen_cursor + SEQ_W'($urandom_range(5, 140));
            h.seq = gen_cursor;
        end else begin
            h.seq = SEQ_W'($urandom_range(255));
        end
        h.key      = ($urandom_range(99) < 85) ? cfg_key : KEY_W'($urandom_range(65535));
        h.kind     = ($urandom_range(99) < 12) ? cfg_ack : KIND_W'($urandom_range(255));
        h.reliable = 1'($urandom_range(1));
        h.payload  = SEQ_W'($urandom_range(255));
        return h;
    endfunction

    // register write: setup cycle then access cycle
    task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_EXPECTED_KEY:  cfg_key = data[KEY_W-1:0];
            REG_ACK_TYPE_CODE: cfg_ack = data[KIND_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every queued header has been sent and answered
    // sampled between edges so the clocked blocks have settled
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_headers.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expv, actv);
            err_count++;
        end
    endtask

    // header driver: predicts each transfer and loads the next header
    always @(posedge aclk) begin
        header_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(filter_header(make_header(
                    s_header_key, s_reliable_flag, s_sequence_number,
                    s_packet_kind, s_first_payload_byte)));
            if (!s_valid || s_ready) begin
                if (pending_headers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_headers.pop_front();
                    s_valid              <= 1'b1;
                    s_header_key         <= nxt.key;
                    s_reliable_flag      <= nxt.reliable;
                    s_sequence_number    <= nxt.seq;
                    s_packet_kind        <= nxt.kind;
                    s_first_payload_byte <= nxt.payload;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no header outstanding");
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("discard",          want.discard,          m_discard);
                    check_field("duplicate",        want.duplicate,        m_duplicate);
                    check_field("send_ack",         want.send_ack,         m_send_ack);
                    check_field("ack_out_sequence", want.ack_out_sequence, m_ack_out_sequence);
                    check_field("acked_valid",      want.acked_valid,      m_acked_valid);
                    check_field("acked_sequence",   want.acked_sequence,   m_acked_sequence);
                    check_field("newest_seen",      want.newest_seen,      m_newest_seen);
                    check_field("window_bits",      want.window_bits,      m_window_bits);
                    n_checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // receiver idles more than sender first
        send_idle_pct = 33;
        recv_idle_pct = 61;

        // directed headers at reset settings: key 0, ack code 0
        pending_headers.push_back(make_header(16'hFFFF, 1'b1, 8'h05, 8'h00, 8'h77)); // bad key, rel ack
        pending_headers.push_back(make_header(16'h0001, 1'b0, 8'h00, 8'h01, 8'h00)); // bad key
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h00, 8'h01, 8'h00)); // mark newest
        pending_headers.push_back(make_header(16'h0000, 1'b1, 8'h00, 8'h01, 8'hFF)); // duplicate
        pending_headers.push_back(make_header(16'h0000, 1'b1, 8'hFF, 8'h00, 8'hFF)); // reliable ack
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h10, 8'h00, 8'h00)); // plain ack
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h01, 8'h01, 8'h00)); // newer by 1
        pending_headers.push_back(make_header(16'h0000, 1'b1, 8'h1F, 8'h01, 8'h00)); // gap 30
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h40, 8'h01, 8'h00)); // gap 33
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h21, 8'h01, 8'h00)); // back 31
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h21, 8'h01, 8'h00)); // dup at 31
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h20, 8'h01, 8'h00)); // back 32
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'hC0, 8'hFF, 8'hFF)); // 128 behind
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'hA0, 8'h01, 8'h00)); // gap 96
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h20, 8'h01, 8'h00)); // 128 newer
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'hFF, 8'h01, 8'h00)); // far behind
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h1F, 8'h01, 8'h00)); // back 1
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'h90, 8'h01, 8'h00));
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'hF0, 8'h01, 8'h00));
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'hFE, 8'h01, 8'h00));
        pending_headers.push_back(make_header(16'h0000, 1'b1, 8'h02, 8'h80, 8'h55)); // across wrap
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'hFF, 8'h01, 8'hAA)); // back 3
        pending_headers.push_back(make_header(16'h0000, 1'b0, 8'hFF, 8'h01, 8'h00)); // dup
        pending_headers.push_back(make_header(16'hFFFF, 1'b0, 8'h02, 8'hFF, 8'hFF)); // bad key
        wait_drained();

        // randomized segments under changing register settings
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg)
                0: begin
                    reg_write(REG_EXPECTED_KEY,  {16'($urandom), 16'hFFFF});
                    reg_write(REG_ACK_TYPE_CODE, {24'($urandom), 8'hFF});
                end
                2: begin
                    reg_write(REG_EXPECTED_KEY,  32'h0000_0000);
                    reg_write(REG_ACK_TYPE_CODE, 32'h0000_0000);
                end
                default: begin
                    reg_write(REG_EXPECTED_KEY,  $urandom);
                    reg_write(REG_ACK_TYPE_CODE, $urandom);
                end
            endcase
            // sender idles more in the middle, then full rate
            if (seg == 2) begin
                send_idle_pct = 61;
                recv_idle_pct = 33;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < SEG_HEADERS; i++)
                pending_headers.push_back(random_header());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d results: %0d key mismatches, %0d duplicates, %0d acks,",
                 n_checked, n_key_miss, n_dup, n_acked);
        $display("%0d window resets, %0d register settings, %0d mismatches",
                 n_win_reset, NUM_SEGMENTS + 1, err_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
